FILE: design/pgcm_pkg.sv
package pgcm_pkg;

    localparam int PGCM_POS_W = 32;
    localparam int PGCM_COL_W = 24;
    localparam int PGCM_CNT_W = 7;

    localparam logic PGCM_CMD_LOAD = 1'b0;
    localparam logic PGCM_CMD_MAP  = 1'b1;

    localparam logic [1:0] PGCM_FMT_555 = 2'd0;
    localparam logic [1:0] PGCM_FMT_565 = 2'd1;
    localparam logic [1:0] PGCM_FMT_24  = 2'd2;
    localparam logic [1:0] PGCM_FMT_32  = 2'd3;

    localparam logic [2:0] REG_BORDER_MIN = 3'd0;
    localparam logic [2:0] REG_BORDER_MAX = 3'd1;
    localparam logic [2:0] REG_USER_MIN   = 3'd2;
    localparam logic [2:0] REG_USER_MAX   = 3'd3;
    localparam logic [2:0] REG_SPAN       = 3'd4;
    localparam logic [2:0] REG_LOW_COLOR  = 3'd5;
    localparam logic [2:0] REG_HIGH_COLOR = 3'd6;
    localparam logic [2:0] REG_FORMAT     = 3'd7;

    // Request to the shared multiply-divide unit: |a| * |b| / divisor, sign applied after.
    typedef struct packed {
        logic [31:0] mul_a;
        logic [31:0] mul_b;
        logic [31:0] divisor;
        logic        neg;
    } pgcm_md_req_t;

endpackage

FILE: design/pgcm_point_ram.sv
module pgcm_point_ram
    import pgcm_pkg::*;
#(
    parameter int DEPTH = 64,
    parameter int AW    = 6
) (
    input  logic                               aclk,
    input  logic                               we,
    input  logic [AW-1:0]                      waddr,
    input  logic [PGCM_COL_W+PGCM_POS_W-1:0]   wdata,
    input  logic [AW-1:0]                      raddr,
    output logic [PGCM_COL_W+PGCM_POS_W-1:0]   rdata
);

    logic [PGCM_COL_W+PGCM_POS_W-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

FILE: design/pgcm_mul_div.sv
module pgcm_mul_div
    import pgcm_pkg::*;
(
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         start,
    input  pgcm_md_req_t req,
    output logic         done,
    output logic [31:0]  quot
);

    localparam int DIV_STEPS = 64;
    localparam int CW = $clog2(DIV_STEPS);

    typedef enum logic [1:0] {MD_IDLE, MD_MUL, MD_DIV} md_state_t;

    md_state_t     state_reg;
    logic [31:0]   a_reg, b_reg, div_reg;
    logic          neg_reg;
    logic [63:0]   dvd_reg;
    logic [32:0]   rem_reg;
    logic [CW-1:0] cnt_reg;
    logic          done_reg;

    logic [32:0] rem_sh;
    logic        ge;

    assign rem_sh = {rem_reg[31:0], dvd_reg[63]};
    assign ge     = rem_sh >= {1'b0, div_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= MD_IDLE;
            done_reg  <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            unique case (state_reg)
                MD_IDLE: begin
                    if (start) begin
                        a_reg     <= req.mul_a;
                        b_reg     <= req.mul_b;
                        div_reg   <= req.divisor;
                        neg_reg   <= req.neg;
                        state_reg <= MD_MUL;
                    end
                end
                MD_MUL: begin
                    dvd_reg   <= a_reg * b_reg;
                    rem_reg   <= '0;
                    cnt_reg   <= '0;
                    state_reg <= MD_DIV;
                end
                MD_DIV: begin
                    rem_reg <= ge ? rem_sh - {1'b0, div_reg} : rem_sh;
                    dvd_reg <= {dvd_reg[62:0], ge};
                    cnt_reg <= cnt_reg + 1'b1;
                    if (cnt_reg == CW'(DIV_STEPS - 1)) begin
                        done_reg  <= 1'b1;
                        state_reg <= MD_IDLE;
                    end
                end
                default: state_reg <= MD_IDLE;
            endcase
        end
    end

    assign done = done_reg;
    assign quot = neg_reg ? (32'd0 - dvd_reg[31:0]) : dvd_reg[31:0];

endmodule

FILE: design/piecewise_gradient_color_map.sv
// Load request: one multiply plus a 64-step shift-subtract divide, unless SPAN is zero.
// Map request: a range walk through the point memory that reads and compares the stored points in turn,
// plus one multiply-divide for each of the three channel divisions when a gradient of nonzero length is hit.
// One request is in work at a time; a finished result waits in the output register.
// Reset (aresetn, synchronous, active low) restores the register defaults and an empty
// point table; point memory contents stay undefined until written.
module piecewise_gradient_color_map
    import pgcm_pkg::*;
#(
    parameter int MAX_POINTS = 64
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [31:0] cfg_data,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic        s_cmd,
    input  logic [5:0]  s_point_index,
    input  logic signed [31:0] s_point_pos,
    input  logic [23:0] s_point_color,
    input  logic signed [31:0] s_sample_value,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [31:0] m_pixel_word,
    output logic        m_range_found
);

    localparam int AW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;

    typedef enum logic [3:0] {
        ST_IDLE, ST_LSTART, ST_LWAIT, ST_R0, ST_RD, ST_CMP, ST_LAST, ST_HIGH,
        ST_BLEND, ST_BWAIT, ST_DONE
    } state_t;

    state_t state_reg;

    logic signed [31:0] bmin_reg, bmax_reg, umin_reg, umax_reg, span_reg;
    logic [23:0]        lowc_reg, highc_reg;
    logic [1:0]         fmt_reg;

    logic [PGCM_CNT_W-1:0] count_reg, j_reg;
    logic [AW-1:0]         idx_reg;
    logic signed [31:0]    pos_reg, v_reg, lo_reg, hi_reg;
    logic [23:0]           pcol_reg, clo_reg, chi_reg, color_reg;
    logic [1:0]            ch_reg;
    logic                  found_reg;

    logic        m_valid_reg, m_found_reg;
    logic [31:0] m_pixel_reg;

    logic         md_start, md_done;
    pgcm_md_req_t md_req;
    logic [31:0]  md_quot;

    logic         ram_we;
    logic [55:0]  ram_wdata, ram_rdata;
    logic signed [31:0] rd_pos;
    logic [23:0]  rd_col;

    // Load operands
    logic [32:0] udiff;
    logic [31:0] pos_mag, udiff_mag, span_mag;
    // Blend operands
    logic [7:0]  ca, cb, d_mag;
    logic [8:0]  d;
    logic [31:0] off, len;

    assign rd_pos = ram_rdata[31:0];
    assign rd_col = ram_rdata[55:32];

    assign udiff     = {umax_reg[31], umax_reg} - {umin_reg[31], umin_reg};
    assign pos_mag   = pos_reg[31] ? 32'd0 - pos_reg : pos_reg;
    assign udiff_mag = udiff[32] ? 32'(33'd0 - udiff) : udiff[31:0];
    assign span_mag  = span_reg[31] ? 32'd0 - span_reg : span_reg;

    assign ca    = clo_reg[ch_reg*8 +: 8];
    assign cb    = chi_reg[ch_reg*8 +: 8];
    assign d     = {1'b0, cb} - {1'b0, ca};
    assign d_mag = d[8] ? 8'(9'd0 - d) : d[7:0];
    assign off   = v_reg - lo_reg;
    assign len   = hi_reg - lo_reg;

    always_comb begin
        if (state_reg == ST_LSTART) begin
            md_req.mul_a   = pos_mag;
            md_req.mul_b   = udiff_mag;
            md_req.divisor = span_mag;
            md_req.neg     = pos_reg[31] ^ udiff[32] ^ span_reg[31];
        end else begin
            md_req.mul_a   = {24'd0, d_mag};
            md_req.mul_b   = off;
            md_req.divisor = len;
            md_req.neg     = d[8];
        end
    end

    assign md_start = (state_reg == ST_LSTART && span_reg != 32'sd0)
                   || (state_reg == ST_BLEND && hi_reg != lo_reg);

    assign ram_we = (state_reg == ST_LSTART && span_reg == 32'sd0)
                 || (state_reg == ST_LWAIT && md_done);
    assign ram_wdata = {pcol_reg,
                        (state_reg == ST_LWAIT) ? umin_reg + md_quot : umin_reg};

    function automatic logic [31:0] pack_pixel(input logic [23:0] c, input logic [1:0] fmt);
        logic [7:0] r, g, b;
        r = c[7:0];
        g = c[15:8];
        b = c[23:16];
        unique case (fmt)
            PGCM_FMT_555: pack_pixel = {17'd0, r[7:3], g[7:3], b[7:3]};
            PGCM_FMT_565: pack_pixel = {16'd0, r[7:3], g[7:2], b[7:3]};
            PGCM_FMT_24,
            PGCM_FMT_32:  pack_pixel = {8'd0, r, g, b};
            default:      pack_pixel = {8'd0, r, g, b};
        endcase
    endfunction

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            bmin_reg    <= 32'sd0;
            bmax_reg    <= 32'sh7fffffff;
            umin_reg    <= 32'sd0;
            umax_reg    <= 32'sd0;
            span_reg    <= 32'sd0;
            lowc_reg    <= 24'd0;
            highc_reg   <= 24'd0;
            fmt_reg     <= PGCM_FMT_32;
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (cfg_we) begin
                unique case (cfg_index)
                    REG_BORDER_MIN: bmin_reg  <= cfg_data;
                    REG_BORDER_MAX: bmax_reg  <= cfg_data;
                    REG_USER_MIN:   umin_reg  <= cfg_data;
                    REG_USER_MAX:   umax_reg  <= cfg_data;
                    REG_SPAN:       span_reg  <= cfg_data;
                    REG_LOW_COLOR:  lowc_reg  <= cfg_data[23:0];
                    REG_HIGH_COLOR: highc_reg <= cfg_data[23:0];
                    REG_FORMAT:     fmt_reg   <= cfg_data[1:0];
                    default: ;
                endcase
            end
            // In ST_DONE the output register is refilled below instead.
            if (m_ready && state_reg != ST_DONE) begin
                m_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE: begin
                    if (s_valid) begin
                        v_reg    <= s_sample_value;
                        pos_reg  <= s_point_pos;
                        pcol_reg <= s_point_color;
                        idx_reg  <= AW'(s_point_index);
                        if (s_cmd == PGCM_CMD_MAP) begin
                            state_reg <= ST_R0;
                        end else if (32'(s_point_index) < MAX_POINTS) begin
                            count_reg <= PGCM_CNT_W'(s_point_index) + 1'b1;
                            state_reg <= ST_LSTART;
                        end
                    end
                end
                ST_LSTART: begin
                    state_reg <= (span_reg == 32'sd0) ? ST_IDLE : ST_LWAIT;
                end
                ST_LWAIT: begin
                    if (md_done) begin
                        state_reg <= ST_IDLE;
                    end
                end
                ST_R0: begin
                    lo_reg  <= umin_reg;
                    clo_reg <= lowc_reg;
                    j_reg   <= '0;
                    if (v_reg >= bmin_reg && v_reg <= umin_reg) begin
                        color_reg <= lowc_reg;
                        found_reg <= 1'b1;
                        state_reg <= ST_DONE;
                    end else begin
                        state_reg <= (count_reg == '0) ? ST_LAST : ST_RD;
                    end
                end
                ST_RD: begin
                    state_reg <= ST_CMP;
                end
                ST_CMP: begin
                    if (v_reg >= lo_reg && v_reg <= rd_pos) begin
                        hi_reg    <= rd_pos;
                        chi_reg   <= rd_col;
                        ch_reg    <= 2'd0;
                        state_reg <= ST_BLEND;
                    end else begin
                        lo_reg  <= rd_pos;
                        clo_reg <= rd_col;
                        j_reg   <= j_reg + 1'b1;
                        state_reg <= (j_reg + 1'b1 == count_reg) ? ST_LAST : ST_RD;
                    end
                end
                ST_LAST: begin
                    hi_reg  <= umax_reg;
                    chi_reg <= highc_reg;
                    ch_reg  <= 2'd0;
                    state_reg <= (v_reg >= lo_reg && v_reg <= umax_reg) ? ST_BLEND : ST_HIGH;
                end
                ST_HIGH: begin
                    state_reg <= ST_DONE;
                    priority if (v_reg >= umax_reg && v_reg <= bmax_reg) begin
                        color_reg <= highc_reg;
                        found_reg <= 1'b1;
                    end else if (v_reg <= bmin_reg) begin
                        color_reg <= lowc_reg;
                        found_reg <= 1'b1;
                    end else if (v_reg >= bmax_reg) begin
                        color_reg <= highc_reg;
                        found_reg <= 1'b1;
                    end else begin
                        color_reg <= 24'd0;
                        found_reg <= 1'b0;
                    end
                end
                ST_BLEND: begin
                    found_reg <= 1'b1;
                    if (hi_reg == lo_reg) begin
                        color_reg <= clo_reg;
                        state_reg <= ST_DONE;
                    end else begin
                        state_reg <= ST_BWAIT;
                    end
                end
                ST_BWAIT: begin
                    if (md_done) begin
                        color_reg[ch_reg*8 +: 8] <= ca + md_quot[7:0];
                        if (ch_reg == 2'd2) begin
                            state_reg <= ST_DONE;
                        end else begin
                            ch_reg    <= ch_reg + 1'b1;
                            state_reg <= ST_BLEND;
                        end
                    end
                end
                ST_DONE: begin
                    if (!m_valid_reg || m_ready) begin
                        m_valid_reg <= 1'b1;
                        m_found_reg <= found_reg;
                        m_pixel_reg <= found_reg ? pack_pixel(color_reg, fmt_reg) : 32'd0;
                        state_reg   <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    pgcm_mul_div u_mul_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (md_start),
        .req     (md_req),
        .done    (md_done),
        .quot    (md_quot)
    );

    pgcm_point_ram #(
        .DEPTH (MAX_POINTS),
        .AW    (AW)
    ) u_point_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (idx_reg),
        .wdata (ram_wdata),
        .raddr (AW'(j_reg)),
        .rdata (ram_rdata)
    );

    assign s_ready       = (state_reg == ST_IDLE);
    assign m_valid       = m_valid_reg;
    assign m_pixel_word  = m_pixel_reg;
    assign m_range_found = m_found_reg;

`ifndef ASSERT_OFF
    a_black_when_missed: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_range_found |-> m_pixel_word == 32'd0)
        else $error("pixel not black for a sample outside every range");

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        32'(count_reg) <= MAX_POINTS)
        else $error("point count beyond table depth");

    a_walk_in_table: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_CMP |-> j_reg < count_reg)
        else $error("range walk read past the last loaded point");

    a_div_done_expected: assert property (@(posedge aclk) disable iff (!aresetn)
        md_done |-> state_reg == ST_LWAIT || state_reg == ST_BWAIT)
        else $error("divider finished with no request waiting for it");
`endif

endmodule
